// ----- src/bbur_pkg.sv -----
// ----------------------------------------------------------------------------
// bbur_pkg
// Shared types and constants of the box union and bounding-sphere pipeline.
// ----------------------------------------------------------------------------
package bbur_pkg;

  localparam int CoordW = 32;  // signed q16.16 center
  localparam int HalfW  = 31;  // unsigned q15.16 half-size
  localparam int ExtW   = 34;  // widened min/max and sums
  localparam int SqW    = 2 * HalfW;
  localparam int SumW   = 64;  // sum of three squares
  localparam int RootW  = SumW / 2;
  localparam int RemW   = RootW + 3;
  localparam int Axes   = 3;

  localparam int MergeStages  = 3;
  localparam int SquareStages = 2;
  localparam int SqrtPerStage = 2;
  localparam int SqrtStages   = RootW / SqrtPerStage;

  typedef struct packed {
    logic signed [CoordW-1:0] first_center_x;
    logic signed [CoordW-1:0] first_center_y;
    logic signed [CoordW-1:0] first_center_z;
    logic [HalfW-1:0]         first_half_x;
    logic [HalfW-1:0]         first_half_y;
    logic [HalfW-1:0]         first_half_z;
    logic signed [CoordW-1:0] second_center_x;
    logic signed [CoordW-1:0] second_center_y;
    logic signed [CoordW-1:0] second_center_z;
    logic [HalfW-1:0]         second_half_x;
    logic [HalfW-1:0]         second_half_y;
    logic [HalfW-1:0]         second_half_z;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] merged_center_x;
    logic signed [CoordW-1:0] merged_center_y;
    logic signed [CoordW-1:0] merged_center_z;
    logic [HalfW-1:0]         merged_half_x;
    logic [HalfW-1:0]         merged_half_y;
    logic [HalfW-1:0]         merged_half_z;
    logic [RootW-1:0]         sphere_radius;
  } out_item_t;

  // merged box, one entry per axis (x, y, z)
  typedef struct packed {
    logic [Axes-1:0][CoordW-1:0] center;
    logic [Axes-1:0][HalfW-1:0]  half;
  } box_t;

  typedef struct packed {
    box_t            box;
    logic [SumW-1:0] sumsq;
  } sq_item_t;

endpackage

// ----- src/bbur_merge.sv -----
// ----------------------------------------------------------------------------
// bbur_merge
// Three-stage box union: bounds, min/max with sum and span, halve and clamp.
// ----------------------------------------------------------------------------
module bbur_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  bbur_pkg::in_item_t item_i,
  output logic               valid_o,
  input  logic               ready_i,
  output bbur_pkg::box_t     box_o
);

  localparam int N = bbur_pkg::MergeStages;

  logic [N-1:0] v_q;
  logic [N:0]   rdy;
  logic [N-1:0] vin;

  logic [bbur_pkg::CoordW-1:0] c1 [bbur_pkg::Axes];
  logic [bbur_pkg::CoordW-1:0] c2 [bbur_pkg::Axes];
  logic [bbur_pkg::HalfW-1:0]  h1 [bbur_pkg::Axes];
  logic [bbur_pkg::HalfW-1:0]  h2 [bbur_pkg::Axes];

  logic signed [bbur_pkg::ExtW-1:0] lo1_d [bbur_pkg::Axes];
  logic signed [bbur_pkg::ExtW-1:0] hi1_d [bbur_pkg::Axes];
  logic signed [bbur_pkg::ExtW-1:0] lo2_d [bbur_pkg::Axes];
  logic signed [bbur_pkg::ExtW-1:0] hi2_d [bbur_pkg::Axes];
  logic signed [bbur_pkg::ExtW-1:0] lo1_q [bbur_pkg::Axes];
  logic signed [bbur_pkg::ExtW-1:0] hi1_q [bbur_pkg::Axes];
  logic signed [bbur_pkg::ExtW-1:0] lo2_q [bbur_pkg::Axes];
  logic signed [bbur_pkg::ExtW-1:0] hi2_q [bbur_pkg::Axes];
  logic signed [bbur_pkg::ExtW-1:0] sum_d [bbur_pkg::Axes];
  logic signed [bbur_pkg::ExtW-1:0] dif_d [bbur_pkg::Axes];
  logic signed [bbur_pkg::ExtW-1:0] sum_q [bbur_pkg::Axes];
  logic signed [bbur_pkg::ExtW-1:0] dif_q [bbur_pkg::Axes];
  bbur_pkg::box_t                   box_d;
  bbur_pkg::box_t                   box_q;

  // stage handshake: a stage takes a beat when empty or draining
  always_comb begin
    rdy[N] = ready_i;
    for (int k = 0; k < N; k++) begin
      rdy[k] = !v_q[k] || rdy[k+1];
      vin[k] = (k == 0) ? valid_i : v_q[(k == 0) ? 0 : k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (rdy[k]) begin
          v_q[k] <= vin[k];
        end
      end
    end
  end

  always_comb begin
    c1[0] = item_i.first_center_x;
    c1[1] = item_i.first_center_y;
    c1[2] = item_i.first_center_z;
    c2[0] = item_i.second_center_x;
    c2[1] = item_i.second_center_y;
    c2[2] = item_i.second_center_z;
    h1[0] = item_i.first_half_x;
    h1[1] = item_i.first_half_y;
    h1[2] = item_i.first_half_z;
    h2[0] = item_i.second_half_x;
    h2[1] = item_i.second_half_y;
    h2[2] = item_i.second_half_z;
  end

  // stage 1: bounds of both boxes
  always_comb begin
    logic signed [bbur_pkg::ExtW-1:0] ce1, ce2, he1, he2;
    for (int a = 0; a < bbur_pkg::Axes; a++) begin
      ce1 = {{(bbur_pkg::ExtW-bbur_pkg::CoordW){c1[a][bbur_pkg::CoordW-1]}}, c1[a]};
      ce2 = {{(bbur_pkg::ExtW-bbur_pkg::CoordW){c2[a][bbur_pkg::CoordW-1]}}, c2[a]};
      he1 = {{(bbur_pkg::ExtW-bbur_pkg::HalfW){1'b0}}, h1[a]};
      he2 = {{(bbur_pkg::ExtW-bbur_pkg::HalfW){1'b0}}, h2[a]};
      lo1_d[a] = ce1 - he1;
      hi1_d[a] = ce1 + he1;
      lo2_d[a] = ce2 - he2;
      hi2_d[a] = ce2 + he2;
    end
  end

  // stage 2: union bounds, then sum and span
  always_comb begin
    logic signed [bbur_pkg::ExtW-1:0] lo, hi;
    for (int a = 0; a < bbur_pkg::Axes; a++) begin
      lo       = (lo1_q[a] < lo2_q[a]) ? lo1_q[a] : lo2_q[a];
      hi       = (hi1_q[a] > hi2_q[a]) ? hi1_q[a] : hi2_q[a];
      sum_d[a] = lo + hi;
      dif_d[a] = hi - lo;
    end
  end

  // stage 3: floor halving and clamp to field range
  always_comb begin
    logic signed [bbur_pkg::ExtW-1:0] ctr;
    logic                             ovf_hi, ovf_lo, ovf_h;
    for (int a = 0; a < bbur_pkg::Axes; a++) begin
      ctr    = sum_q[a] >>> 1;
      ovf_hi = !ctr[bbur_pkg::ExtW-1] && (|ctr[bbur_pkg::ExtW-2:bbur_pkg::CoordW-1]);
      ovf_lo = ctr[bbur_pkg::ExtW-1] && !(&ctr[bbur_pkg::ExtW-2:bbur_pkg::CoordW-1]);
      if (ovf_hi) begin
        box_d.center[a] = {1'b0, {(bbur_pkg::CoordW-1){1'b1}}};
      end else if (ovf_lo) begin
        box_d.center[a] = {1'b1, {(bbur_pkg::CoordW-1){1'b0}}};
      end else begin
        box_d.center[a] = ctr[bbur_pkg::CoordW-1:0];
      end
      // span is never negative
      ovf_h = |dif_q[a][bbur_pkg::ExtW-2:bbur_pkg::HalfW+1];
      box_d.half[a] = ovf_h ? {bbur_pkg::HalfW{1'b1}} : dif_q[a][bbur_pkg::HalfW:1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < bbur_pkg::Axes; a++) begin
      if (rdy[0] && vin[0]) begin
        lo1_q[a] <= lo1_d[a];
        hi1_q[a] <= hi1_d[a];
        lo2_q[a] <= lo2_d[a];
        hi2_q[a] <= hi2_d[a];
      end
      if (rdy[1] && vin[1]) begin
        sum_q[a] <= sum_d[a];
        dif_q[a] <= dif_d[a];
      end
    end
    if (rdy[2] && vin[2]) begin
      box_q <= box_d;
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[N-1];
  assign box_o   = box_q;

endmodule

// ----- src/bbur_square.sv -----
// ----------------------------------------------------------------------------
// bbur_square
// Two-stage sum of squared half-sizes: square per axis, then add the three.
// ----------------------------------------------------------------------------
module bbur_square (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  bbur_pkg::box_t     box_i,
  output logic               valid_o,
  input  logic               ready_i,
  output bbur_pkg::sq_item_t sq_o
);

  localparam int N = bbur_pkg::SquareStages;

  logic [N-1:0] v_q;
  logic [N:0]   rdy;
  logic [N-1:0] vin;

  logic [bbur_pkg::SqW-1:0] sq_d [bbur_pkg::Axes];
  logic [bbur_pkg::SqW-1:0] sq_q [bbur_pkg::Axes];
  bbur_pkg::box_t           box_q;
  bbur_pkg::sq_item_t       out_d;
  bbur_pkg::sq_item_t       out_q;

  always_comb begin
    rdy[N] = ready_i;
    for (int k = 0; k < N; k++) begin
      rdy[k] = !v_q[k] || rdy[k+1];
      vin[k] = (k == 0) ? valid_i : v_q[(k == 0) ? 0 : k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (rdy[k]) begin
          v_q[k] <= vin[k];
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < bbur_pkg::Axes; a++) begin
      sq_d[a] = box_i.half[a] * box_i.half[a];
    end
  end

  always_comb begin
    out_d.box   = box_q;
    out_d.sumsq = bbur_pkg::SumW'(sq_q[0]) + bbur_pkg::SumW'(sq_q[1])
                + bbur_pkg::SumW'(sq_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && vin[0]) begin
      for (int a = 0; a < bbur_pkg::Axes; a++) begin
        sq_q[a] <= sq_d[a];
      end
      box_q <= box_i;
    end
    if (rdy[1] && vin[1]) begin
      out_q <= out_d;
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[N-1];
  assign sq_o    = out_q;

endmodule

// ----- src/bbur_sqrt.sv -----
// ----------------------------------------------------------------------------
// bbur_sqrt
// Pipelined digit-by-digit floor square root, two result bits per stage.
// ----------------------------------------------------------------------------
module bbur_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  bbur_pkg::sq_item_t  sq_i,
  output logic                valid_o,
  input  logic                ready_i,
  output bbur_pkg::out_item_t item_o
);

  localparam int N = bbur_pkg::SqrtStages;

  logic [N-1:0] v_q;
  logic [N:0]   rdy;
  logic [N-1:0] vin;

  logic [bbur_pkg::SumW-1:0]  x_d    [N];
  logic [bbur_pkg::SumW-1:0]  x_q    [N];
  logic [bbur_pkg::RemW-1:0]  rem_d  [N];
  logic [bbur_pkg::RemW-1:0]  rem_q  [N];
  logic [bbur_pkg::RootW-1:0] root_d [N];
  logic [bbur_pkg::RootW-1:0] root_q [N];
  bbur_pkg::box_t             box_d  [N];
  bbur_pkg::box_t             box_q  [N];

  always_comb begin
    rdy[N] = ready_i;
    for (int k = 0; k < N; k++) begin
      rdy[k] = !v_q[k] || rdy[k+1];
      vin[k] = (k == 0) ? valid_i : v_q[(k == 0) ? 0 : k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (rdy[k]) begin
          v_q[k] <= vin[k];
        end
      end
    end
  end

  // each step brings down two radicand bits and tries the next root bit
  always_comb begin
    logic [bbur_pkg::SumW-1:0]  x;
    logic [bbur_pkg::RemW-1:0]  rem, rem2, trial;
    logic [bbur_pkg::RootW-1:0] root;
    for (int s = 0; s < N; s++) begin
      if (s == 0) begin
        x        = sq_i.sumsq;
        rem      = '0;
        root     = '0;
        box_d[s] = sq_i.box;
      end else begin
        x        = x_q[(s == 0) ? 0 : s-1];
        rem      = rem_q[(s == 0) ? 0 : s-1];
        root     = root_q[(s == 0) ? 0 : s-1];
        box_d[s] = box_q[(s == 0) ? 0 : s-1];
      end
      for (int k = 0; k < bbur_pkg::SqrtPerStage; k++) begin
        rem2  = {rem[bbur_pkg::RemW-3:0], x[bbur_pkg::SumW-1 -: 2]};
        x     = {x[bbur_pkg::SumW-3:0], 2'b00};
        trial = {{(bbur_pkg::RemW-bbur_pkg::RootW-2){1'b0}}, root, 2'b01};
        if (rem2 >= trial) begin
          rem  = rem2 - trial;
          root = {root[bbur_pkg::RootW-2:0], 1'b1};
        end else begin
          rem  = rem2;
          root = {root[bbur_pkg::RootW-2:0], 1'b0};
        end
      end
      x_d[s]    = x;
      rem_d[s]  = rem;
      root_d[s] = root;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < N; s++) begin
      if (rdy[s] && vin[s]) begin
        x_q[s]    <= x_d[s];
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
        box_q[s]  <= box_d[s];
      end
    end
  end

  always_comb begin
    item_o.merged_center_x = box_q[N-1].center[0];
    item_o.merged_center_y = box_q[N-1].center[1];
    item_o.merged_center_z = box_q[N-1].center[2];
    item_o.merged_half_x   = box_q[N-1].half[0];
    item_o.merged_half_y   = box_q[N-1].half[1];
    item_o.merged_half_z   = box_q[N-1].half[2];
    item_o.sphere_radius   = root_q[N-1];
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[N-1];

endmodule

// ----- src/bounding_box_union_radius_top.sv -----
// ----------------------------------------------------------------------------
// bounding_box_union_radius_top
// Union of two axis-aligned boxes with the radius of its bounding sphere.
// ----------------------------------------------------------------------------
// usage:
//   in channel  : in_valid_i / in_ready_o / in_item_i, one box pair per beat
//   out channel : out_valid_o / out_ready_i / out_item_o, one result per beat
//   each beat gives merged center and half-size per axis (saturated) and the
//   floor square root of the summed squared half-sizes
// pipeline: 3 merge stages, 2 square/add stages and 16 square-root stages
//   of two bits each
// throughput: one beat per cycle unless every stage is full and out_ready_i is low;
//   set by the square-root pipeline, which takes a new radicand every cycle
// reset: all stage valid bits clear, so the pipeline comes up empty and
//   ready; the data registers are not reset
// stalls: when out_ready_i is low the output beat holds; earlier stages keep
//   filling any empty slots, and in_ready_o drops only once every stage
//   holds a beat
// ----------------------------------------------------------------------------
module bounding_box_union_radius_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bbur_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bbur_pkg::out_item_t out_item_o
);

  logic               mrg_valid, mrg_ready;
  bbur_pkg::box_t     mrg_box;
  logic               sq_valid, sq_ready;
  bbur_pkg::sq_item_t sq_item;

  bbur_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item_i),
    .valid_o (mrg_valid),
    .ready_i (mrg_ready),
    .box_o   (mrg_box)
  );

  bbur_square u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mrg_valid),
    .ready_o (mrg_ready),
    .box_i   (mrg_box),
    .valid_o (sq_valid),
    .ready_i (sq_ready),
    .sq_o    (sq_item)
  );

  bbur_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .ready_o (sq_ready),
    .sq_i    (sq_item),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .item_o  (out_item_o)
  );

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  logic [bbur_pkg::HalfW+1:0] half_sum;
  assign half_sum = (bbur_pkg::HalfW+2)'(out_item_o.merged_half_x)
                  + (bbur_pkg::HalfW+2)'(out_item_o.merged_half_y)
                  + (bbur_pkg::HalfW+2)'(out_item_o.merged_half_z);

  // input side blocks only when every stage holds a beat and the sink stalls
  a_full_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while pipeline has room");

  // radius covers the largest half-size
  a_radius_lower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.sphere_radius >= 32'(out_item_o.merged_half_x))
                 && (out_item_o.sphere_radius >= 32'(out_item_o.merged_half_y))
                 && (out_item_o.sphere_radius >= 32'(out_item_o.merged_half_z)))
    else $error("sphere radius below a half-size");

  // radius never exceeds the sum of half-sizes
  a_radius_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((bbur_pkg::HalfW+2)'(out_item_o.sphere_radius) <= half_sum))
    else $error("sphere radius above sum of half-sizes");

endmodule
